[design/avr_alu_pkg.sv]
// ----------------------------------------------------------------------------
// avr_alu_pkg
// Shared types and constants for the AVR ALU execute block.
// ----------------------------------------------------------------------------
package avr_alu_pkg;

    typedef enum logic [2:0] {
        MODE_EOR = 3'd0,
        MODE_CPI = 3'd1,
        MODE_CPC = 3'd2,
        MODE_ORI = 3'd3,
        MODE_AND = 3'd4,
        MODE_ADD = 3'd5
    } alu_mode_t;

    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_N = 2;
    localparam int FLAG_V = 3;
    localparam int FLAG_S = 4;
    localparam int FLAG_H = 5;

    localparam int REG_COUNT  = 32;
    localparam int REG_AW     = 5;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        alu_mode_t         mode;
        logic [REG_AW-1:0] dest;
        logic [REG_AW-1:0] src;
        logic [7:0]        imm;
        logic              use_imm;
        logic              wr;
    } alu_op_t;

endpackage

[design/avr_alu_in_if.sv]
// ----------------------------------------------------------------------------
// avr_alu_in_if
// Instruction channel: operation mode and instruction word with valid/ready.
// ----------------------------------------------------------------------------
interface avr_alu_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  mode;
    logic [15:0] instr_word;

    modport source (output valid, output mode, output instr_word, input ready);
    modport sink (input valid, input mode, input instr_word, output ready);
endinterface

[design/avr_alu_out_if.sv]
// ----------------------------------------------------------------------------
// avr_alu_out_if
// Result channel: ALU result, destination, write flag and status register.
// ----------------------------------------------------------------------------
interface avr_alu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;
    logic [4:0] dest_index;
    logic       dest_written;
    logic [7:0] status_after;

    modport source (output valid, output result_byte, output dest_index,
                    output dest_written, output status_after, input ready);
    modport sink (input valid, input result_byte, input dest_index,
                  input dest_written, input status_after, output ready);
endinterface

[design/avr_alu_front.sv]
// ----------------------------------------------------------------------------
// avr_alu_front
// Accepts instructions, decodes register and immediate fields, and queues
// the decoded operations for the execute side.
// ----------------------------------------------------------------------------
module avr_alu_front
    import avr_alu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    avr_alu_in_if.sink    in_ch,
    output alu_op_t       q_op,
    output logic          q_valid,
    input  logic          q_ready
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    alu_op_t           entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;
    alu_op_t           dec_op;
    alu_mode_t         mode;
    logic [15:0]       w;

    assign w    = in_ch.instr_word;
    assign mode = alu_mode_t'(in_ch.mode);

    always_comb
    begin
        dec_op.mode    = mode;
        dec_op.dest    = w[8:4];
        dec_op.src     = {w[9], w[3:0]};
        dec_op.imm     = {w[11:8], w[3:0]};
        dec_op.use_imm = 1'b0;
        dec_op.wr      = 1'b0;
        case (mode)
            MODE_EOR, MODE_AND, MODE_ADD:
            begin
                dec_op.wr = 1'b1;
            end
            MODE_ORI:
            begin
                dec_op.dest    = {1'b1, w[7:4]};
                dec_op.use_imm = 1'b1;
                dec_op.wr      = 1'b1;
            end
            MODE_CPI:
            begin
                dec_op.dest    = {1'b1, w[7:4]};
                dec_op.use_imm = 1'b1;
            end
            default:
            begin
                dec_op.wr = 1'b0;
            end
        endcase
    end

    assign in_ch.ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign q_valid     = (count_reg != '0);
    assign q_op        = entries_reg[rd_ptr_reg];
    assign push        = in_ch.valid && in_ch.ready;
    assign pop         = q_valid && q_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= dec_op;
        end
    end

endmodule

[design/avr_alu_back.sv]
// ----------------------------------------------------------------------------
// avr_alu_back
// Reads operands from the register file, executes the operation, updates
// the status register and holds the result in an output register.
// ----------------------------------------------------------------------------
module avr_alu_back
    import avr_alu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  alu_op_t        q_op,
    input  logic           q_valid,
    output logic           q_ready,
    avr_alu_out_if.source  out_ch
);

    logic [7:0]           regfile_reg [REG_COUNT];
    logic [REG_COUNT-1:0] written_reg;
    logic [7:0]           raw_a_reg;
    logic [7:0]           raw_b_reg;
    logic                 vld_a_reg;
    logic                 vld_b_reg;
    logic                 byp_a_reg;
    logic                 byp_b_reg;
    logic [7:0]           fwd_reg;
    alu_op_t              op_reg;
    logic                 busy_reg;
    logic                 busy_next;
    logic [7:0]           status_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_result_reg;
    logic [4:0]           out_dest_reg;
    logic                 out_wr_reg;
    logic [7:0]           out_status_reg;

    logic                 done;
    logic                 load;
    logic                 wr_fire;
    logic [7:0]           a;
    logic [7:0]           b;
    logic [7:0]           res;
    logic [7:0]           s;
    logic                 a7, b7, r7, a3, b3, r3;

    assign done    = busy_reg && (!out_valid_reg || out_ch.ready);
    assign load    = q_valid && (!busy_reg || done);
    assign q_ready = !busy_reg || done;
    assign wr_fire = done && op_reg.wr;

    assign a = byp_a_reg ? fwd_reg : (vld_a_reg ? raw_a_reg : 8'h00);
    assign b = op_reg.use_imm ? op_reg.imm
             : (byp_b_reg ? fwd_reg : (vld_b_reg ? raw_b_reg : 8'h00));

    always_comb
    begin
        s   = status_reg;
        res = 8'h00;
        case (op_reg.mode)
            MODE_EOR: res = a ^ b;
            MODE_ORI: res = a | b;
            MODE_AND: res = a & b;
            MODE_CPI: res = a - b;
            MODE_CPC: res = a - b - {7'd0, status_reg[FLAG_C]};
            MODE_ADD: res = a + b;
            default:  res = 8'h00;
        endcase
        a7 = a[7];
        b7 = b[7];
        r7 = res[7];
        a3 = a[3];
        b3 = b[3];
        r3 = res[3];
        case (op_reg.mode)
            MODE_EOR, MODE_ORI, MODE_AND:
            begin
                s[FLAG_Z] = (res == 8'h00);
                s[FLAG_V] = 1'b0;
                s[FLAG_N] = r7;
                s[FLAG_S] = r7;
            end
            MODE_CPI, MODE_CPC:
            begin
                s[FLAG_C] = (!a7 && b7) || (b7 && r7) || (r7 && !a7);
                s[FLAG_V] = (a7 && !b7 && !r7) || (!a7 && b7 && r7);
                s[FLAG_H] = (!a3 && b3) || (b3 && r3) || (r3 && !a3);
                if (op_reg.mode == MODE_CPI)
                begin
                    s[FLAG_Z] = (res == 8'h00);
                end
                else if (res != 8'h00)
                begin
                    s[FLAG_Z] = 1'b0;
                end
                s[FLAG_N] = r7;
                s[FLAG_S] = r7 ^ s[FLAG_V];
            end
            MODE_ADD:
            begin
                s[FLAG_C] = (a7 && b7) || (b7 && !r7) || (!r7 && a7);
                s[FLAG_V] = (a7 && b7 && !r7) || (!a7 && !b7 && r7);
                s[FLAG_H] = (a3 && b3) || (b3 && !r3) || (!r3 && a3);
                s[FLAG_Z] = (res == 8'h00);
                s[FLAG_N] = r7;
                s[FLAG_S] = r7 ^ s[FLAG_V];
            end
            default:
            begin
                s = status_reg;
            end
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        if (load)
        begin
            busy_next = 1'b1;
        end
        else if (done)
        begin
            busy_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            status_reg    <= 8'h00;
            written_reg   <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (done)
            begin
                status_reg <= s;
            end
            if (wr_fire)
            begin
                written_reg[op_reg.dest] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_fire)
        begin
            regfile_reg[op_reg.dest] <= res;
        end
        if (load)
        begin
            raw_a_reg <= regfile_reg[q_op.dest];
            raw_b_reg <= regfile_reg[q_op.src];
            vld_a_reg <= written_reg[q_op.dest];
            vld_b_reg <= written_reg[q_op.src];
            byp_a_reg <= wr_fire && (op_reg.dest == q_op.dest);
            byp_b_reg <= wr_fire && (op_reg.dest == q_op.src);
            fwd_reg   <= res;
            op_reg    <= q_op;
        end
        if (done)
        begin
            out_result_reg <= res;
            out_dest_reg   <= op_reg.dest;
            out_wr_reg     <= op_reg.wr;
            out_status_reg <= s;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_byte  = out_result_reg;
    assign out_ch.dest_index   = out_dest_reg;
    assign out_ch.dest_written = out_wr_reg;
    assign out_ch.status_after = out_status_reg;

endmodule

[design/avr_alu_logic_arith_execute_top.sv]
// ----------------------------------------------------------------------------
// avr_alu_logic_arith_execute_top
// AVR 8-bit ALU execute block with register file and status register.
// ----------------------------------------------------------------------------
// Instructions arrive on in_ch as a mode and a 16-bit instruction word; each
// transfer yields exactly one result transfer on out_ch carrying the result
// byte, the destination register, a write flag and the new status register.
// The front decodes each instruction into a two-entry queue. The back reads
// both operands from the 32-entry register file into registers, executes
// the operation, writes back and updates the flags, and loads the output
// register.
// An instruction passes from its queue entry through the operand registers
// to the output register; one instruction per cycle while out_ch is ready.
// A dependent instruction directly behind its producer takes the result
// through a forwarding path. When out_ch stalls, the execute stage holds
// and the queue fills, then in_ch.ready drops; no result is lost or repeated.
// Reset clears the queue, the pipeline, the status register and the written
// marks of the register file, so every register reads as zero until it is
// first written.
// ----------------------------------------------------------------------------
module avr_alu_logic_arith_execute_top
    import avr_alu_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    avr_alu_in_if.sink     in_ch,
    avr_alu_out_if.source  out_ch
);

    alu_op_t q_op;
    logic    q_valid;
    logic    q_ready;

    avr_alu_front u_front
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_op    (q_op),
        .q_valid (q_valid),
        .q_ready (q_ready)
    );

    avr_alu_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_op    (q_op),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .out_ch  (out_ch)
    );

endmodule
